[sv/rtpf_pkg.sv]
// ----------------------------------------------------------------------------
// rtpf_pkg: shared types and constants of the range target persistence filter
// Field widths, register codes, reset values, sequencer states and the
// shared adder's operation and result types.
// ----------------------------------------------------------------------------
package rtpf_pkg;

  // Field widths
  localparam int RANGE_W    = 16;  // Q12.4 centimetre sample
  localparam int MARGIN_W   = 8;   // margin, fraction times 256
  localparam int HITS_W     = 5;   // hit count, 0 to 16
  localparam int SUM_W      = 20;  // sum of up to 16 samples
  localparam int PROD_W     = 20;  // sample times count, and its distance from the sum
  localparam int ALU_W      = 28;  // margin product, 20 by 8 bits
  localparam int REM_W      = 4;   // division remainder, below the count
  localparam int STEP_W     = 5;   // sequencer step counter
  localparam int BIT_SEL_W  = 3;   // selects one multiplier bit

  // Largest history depth that the sum and remainder widths can hold
  localparam int DEPTH_MAX  = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN_Q8 = 2'd1;

  // Register reset values
  localparam logic [RANGE_W-1:0]  MAX_RANGE_RST = 16'd16000;
  localparam logic [MARGIN_W-1:0] MARGIN_RST    = 8'd51;

  // Default hits needed to report a target
  localparam int MIN_HITS_DEF = 3;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,   // wait for a sample word
    ST_SUM,    // accumulate stored samples
    ST_MULN,   // sample times count, shift and add
    ST_DIFF,   // product minus sum
    ST_NEG,    // sum minus product when the first difference went negative
    ST_MULM,   // sum times margin, shift and add
    ST_CMP,    // compare scaled distance with margin product
    ST_UPD,    // store the sample, update the count
    ST_DIV,    // restoring division for the mean
    ST_OUT     // hand the result word to the output register
  } state_t;

  // Shared adder
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic             carry;  // on subtract: set when a >= b
    logic [ALU_W-1:0] res;
  } alu_res_t;

endpackage

[sv/rtpf_in_if.sv]
// ----------------------------------------------------------------------------
// rtpf_in_if: sample channel
// Valid/ready channel that carries one range sample per word.
// ----------------------------------------------------------------------------
interface rtpf_in_if;
  logic                         valid;
  logic                         ready;
  logic [rtpf_pkg::RANGE_W-1:0] range_sample;

  modport source (output valid, output range_sample, input ready);
  modport sink   (input valid, input range_sample, output ready);
endinterface

[sv/rtpf_out_if.sv]
// ----------------------------------------------------------------------------
// rtpf_out_if: result channel
// Valid/ready channel that carries detection flag, hit count and mean range.
// ----------------------------------------------------------------------------
interface rtpf_out_if;
  logic                         valid;
  logic                         ready;
  logic                         detected;
  logic [rtpf_pkg::HITS_W-1:0]  hit_count;
  logic [rtpf_pkg::RANGE_W-1:0] mean_range;

  modport source (output valid, output detected, output hit_count, output mean_range,
                  input ready);
  modport sink   (input valid, input detected, input hit_count, input mean_range,
                  output ready);
endinterface

[sv/range_target_persistence_filter.sv]
// ----------------------------------------------------------------------------
// range_target_persistence_filter: top level
// A zero or out-of-range sample word clears the history and goes straight to
//   the result word; any other runs the sum, multiply, difference, margin
//   multiply, compare, update and division steps (a negate step more when
//   the sample lies below the mean; an empty history skips from sum to
//   update). One shared 28-bit adder does every sum, shift-and-add multiply,
//   compare and division step. The next sample is taken once the result sits
//   in the output register.
// Reset: synchronous; history and hit count cleared, registers at defaults.
// ----------------------------------------------------------------------------
module range_target_persistence_filter #(
  parameter int MIN_HITS = rtpf_pkg::MIN_HITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  rtpf_in_if.sink                         samples,
  rtpf_out_if.source                      results,
  input  logic                            wr_en,
  input  logic [rtpf_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [rtpf_pkg::CFG_DATA_W-1:0] wr_data
);

  localparam int HIST_DEPTH = MIN_HITS + 1;
  localparam int IDX_W      = $clog2(HIST_DEPTH);
  localparam logic [rtpf_pkg::HITS_W-1:0] HITS_LIMIT = rtpf_pkg::HITS_W'(HIST_DEPTH);
  localparam logic [rtpf_pkg::HITS_W-1:0] HITS_DET   = rtpf_pkg::HITS_W'(MIN_HITS);

  // Configuration registers
  logic [rtpf_pkg::RANGE_W-1:0]  max_range;
  logic [rtpf_pkg::MARGIN_W-1:0] margin_q8;

  // Sequencer and datapath registers
  rtpf_pkg::state_t              state, state_next;
  logic [rtpf_pkg::STEP_W-1:0]   step;
  logic [rtpf_pkg::RANGE_W-1:0]  d;
  logic [rtpf_pkg::HITS_W-1:0]   hits;
  logic [rtpf_pkg::SUM_W-1:0]    acc;
  logic [rtpf_pkg::PROD_W-1:0]   pa;
  logic [rtpf_pkg::ALU_W-1:0]    pb;
  logic                          accept;
  logic                          det;
  logic [rtpf_pkg::REM_W-1:0]    rem;
  logic [rtpf_pkg::RANGE_W-1:0]  quo;

  // Output register
  logic                          out_valid;
  logic                          out_det;
  logic [rtpf_pkg::HITS_W-1:0]   out_hits;
  logic [rtpf_pkg::RANGE_W-1:0]  out_mean;

  // Combinational control
  logic                          sample_bad;
  logic                          out_free;
  logic                          n_bit;
  logic                          m_bit;
  logic [rtpf_pkg::HITS_W-1:0]   hits_after;
  rtpf_pkg::alu_op_t             alu_op;
  logic [rtpf_pkg::ALU_W-1:0]    alu_a;
  logic [rtpf_pkg::ALU_W-1:0]    alu_b;
  rtpf_pkg::alu_res_t            alu_r;
  logic                          hist_clr;
  logic                          hist_we;
  logic [rtpf_pkg::RANGE_W-1:0]  hist_rdata;

  assign sample_bad = (samples.range_sample == '0) || (samples.range_sample > max_range);
  assign out_free   = !out_valid || results.ready;
  assign n_bit      = hits[step[rtpf_pkg::BIT_SEL_W-1:0]];
  assign m_bit      = margin_q8[step[rtpf_pkg::BIT_SEL_W-1:0]];
  assign hits_after = hist_we ? hits + rtpf_pkg::HITS_W'(1) : hits;

  // Shared adder
  rtpf_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .result (alu_r)
  );

  // History store
  rtpf_hist #(
    .DEPTH (HIST_DEPTH),
    .IDX_W (IDX_W)
  ) u_hist (
    .clk   (clk),
    .rst   (rst),
    .clr   (hist_clr),
    .we    (hist_we),
    .waddr (hits[IDX_W-1:0]),
    .wdata (d),
    .raddr (step[IDX_W-1:0]),
    .rdata (hist_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rtpf_pkg::ST_IDLE: begin
        if (samples.valid) begin
          state_next = sample_bad ? rtpf_pkg::ST_DIV : rtpf_pkg::ST_SUM;
        end
      end
      rtpf_pkg::ST_SUM: begin
        if (rtpf_pkg::HITS_W'(step) == hits) begin
          state_next = (hits == '0) ? rtpf_pkg::ST_UPD : rtpf_pkg::ST_MULN;
        end
      end
      rtpf_pkg::ST_MULN: begin
        if (step == '0) state_next = rtpf_pkg::ST_DIFF;
      end
      rtpf_pkg::ST_DIFF: begin
        state_next = alu_r.carry ? rtpf_pkg::ST_MULM : rtpf_pkg::ST_NEG;
      end
      rtpf_pkg::ST_NEG: state_next = rtpf_pkg::ST_MULM;
      rtpf_pkg::ST_MULM: begin
        if (step == '0) state_next = rtpf_pkg::ST_CMP;
      end
      rtpf_pkg::ST_CMP: state_next = rtpf_pkg::ST_UPD;
      rtpf_pkg::ST_UPD: state_next = rtpf_pkg::ST_DIV;
      rtpf_pkg::ST_DIV: begin
        if (hits == '0 || step == '0) state_next = rtpf_pkg::ST_OUT;
      end
      rtpf_pkg::ST_OUT: begin
        if (out_free) state_next = rtpf_pkg::ST_IDLE;
      end
      default: state_next = rtpf_pkg::ST_IDLE;
    endcase
  end

  // Adder operands and store strobes
  always_comb begin
    alu_op        = rtpf_pkg::ALU_ADD;
    alu_a         = '0;
    alu_b         = '0;
    hist_clr      = 1'b0;
    hist_we       = 1'b0;
    samples.ready = 1'b0;
    unique case (state)
      rtpf_pkg::ST_IDLE: begin
        samples.ready = 1'b1;
        hist_clr      = samples.valid && sample_bad;
      end
      rtpf_pkg::ST_SUM: begin
        alu_a = rtpf_pkg::ALU_W'(acc);
        alu_b = rtpf_pkg::ALU_W'(hist_rdata);
      end
      rtpf_pkg::ST_MULN: begin
        alu_a = rtpf_pkg::ALU_W'({pa, 1'b0});
        alu_b = n_bit ? rtpf_pkg::ALU_W'(d) : '0;
      end
      rtpf_pkg::ST_DIFF: begin
        alu_op = rtpf_pkg::ALU_SUB;
        alu_a  = rtpf_pkg::ALU_W'(pa);
        alu_b  = rtpf_pkg::ALU_W'(acc);
      end
      rtpf_pkg::ST_NEG: begin
        alu_op = rtpf_pkg::ALU_SUB;
        alu_a  = rtpf_pkg::ALU_W'(acc);
        alu_b  = rtpf_pkg::ALU_W'(pa);
      end
      rtpf_pkg::ST_MULM: begin
        alu_a = {pb[rtpf_pkg::ALU_W-2:0], 1'b0};
        alu_b = m_bit ? rtpf_pkg::ALU_W'(acc) : '0;
      end
      rtpf_pkg::ST_CMP: begin
        alu_op = rtpf_pkg::ALU_SUB;
        alu_a  = pb;
        alu_b  = rtpf_pkg::ALU_W'({pa, 8'h00});
      end
      rtpf_pkg::ST_UPD: begin
        alu_a   = rtpf_pkg::ALU_W'(acc);
        alu_b   = rtpf_pkg::ALU_W'(d);
        hist_we = accept && (hits < HITS_LIMIT);
      end
      rtpf_pkg::ST_DIV: begin
        alu_op = rtpf_pkg::ALU_SUB;
        alu_a  = rtpf_pkg::ALU_W'({rem, quo[rtpf_pkg::RANGE_W-1]});
        alu_b  = rtpf_pkg::ALU_W'(hits);
      end
      rtpf_pkg::ST_OUT: begin
        alu_op = rtpf_pkg::ALU_ADD;
      end
      default: begin
        alu_op = rtpf_pkg::ALU_ADD;
      end
    endcase
  end

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      max_range <= rtpf_pkg::MAX_RANGE_RST;
      margin_q8 <= rtpf_pkg::MARGIN_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        rtpf_pkg::REG_MAX_RANGE: max_range <= wr_data[rtpf_pkg::RANGE_W-1:0];
        rtpf_pkg::REG_MARGIN_Q8: margin_q8 <= wr_data[rtpf_pkg::MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rtpf_pkg::ST_IDLE;
      hits      <= '0;
      det       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // Clear the count on a no-target sample, advance it on a stored one
      if (hist_clr) begin
        hits <= '0;
        det  <= 1'b0;
      end else if (state == rtpf_pkg::ST_UPD) begin
        hits <= hits_after;
        det  <= accept && (hits_after >= HITS_DET);
      end
      // Output word valid until taken, reloaded when a new one is ready
      if (state == rtpf_pkg::ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      rtpf_pkg::ST_IDLE: begin
        d    <= samples.range_sample;
        step <= '0;
        acc  <= '0;
        rem  <= '0;
        quo  <= '0;
      end
      rtpf_pkg::ST_SUM: begin
        if (rtpf_pkg::HITS_W'(step) == hits) begin
          pa     <= '0;
          pb     <= '0;
          accept <= (hits == '0);
          step   <= rtpf_pkg::STEP_W'(rtpf_pkg::HITS_W - 1);
        end else begin
          acc  <= alu_r.res[rtpf_pkg::SUM_W-1:0];
          step <= step + rtpf_pkg::STEP_W'(1);
        end
      end
      rtpf_pkg::ST_MULN: begin
        pa   <= alu_r.res[rtpf_pkg::PROD_W-1:0];
        step <= step - rtpf_pkg::STEP_W'(1);
      end
      rtpf_pkg::ST_DIFF: begin
        if (alu_r.carry) pa <= alu_r.res[rtpf_pkg::PROD_W-1:0];
        step <= rtpf_pkg::STEP_W'(rtpf_pkg::MARGIN_W - 1);
      end
      rtpf_pkg::ST_NEG: begin
        pa <= alu_r.res[rtpf_pkg::PROD_W-1:0];
      end
      rtpf_pkg::ST_MULM: begin
        pb   <= alu_r.res;
        step <= step - rtpf_pkg::STEP_W'(1);
      end
      rtpf_pkg::ST_CMP: begin
        accept <= alu_r.carry;
      end
      rtpf_pkg::ST_UPD: begin
        // Load the divider from the sum after the update
        step <= rtpf_pkg::STEP_W'(rtpf_pkg::RANGE_W - 1);
        if (hist_we) begin
          acc <= alu_r.res[rtpf_pkg::SUM_W-1:0];
          rem <= alu_r.res[rtpf_pkg::SUM_W-1:rtpf_pkg::RANGE_W];
          quo <= alu_r.res[rtpf_pkg::RANGE_W-1:0];
        end else begin
          rem <= acc[rtpf_pkg::SUM_W-1:rtpf_pkg::RANGE_W];
          quo <= acc[rtpf_pkg::RANGE_W-1:0];
        end
      end
      rtpf_pkg::ST_DIV: begin
        // One quotient bit per cycle, restore on borrow
        if (hits != '0) begin
          if (alu_r.carry) begin
            rem <= alu_r.res[rtpf_pkg::REM_W-1:0];
            quo <= {quo[rtpf_pkg::RANGE_W-2:0], 1'b1};
          end else begin
            rem <= {rem[rtpf_pkg::REM_W-2:0], quo[rtpf_pkg::RANGE_W-1]};
            quo <= {quo[rtpf_pkg::RANGE_W-2:0], 1'b0};
          end
          step <= step - rtpf_pkg::STEP_W'(1);
        end
      end
      rtpf_pkg::ST_OUT: begin
        if (out_free) begin
          out_det  <= det;
          out_hits <= hits;
          out_mean <= quo;
        end
      end
      default: ;
    endcase
  end

  // Result word
  assign results.valid      = out_valid;
  assign results.detected   = out_det;
  assign results.hit_count  = out_hits;
  assign results.mean_range = out_mean;

  // Hit count never passes the history depth
  a_hits_bound: assert property (@(posedge clk) disable iff (rst)
    hits <= HITS_LIMIT)
    else $error("hit count beyond history depth");

  // A reported target carries enough hits
  a_det_hits: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.detected |-> results.hit_count >= HITS_DET)
    else $error("detected with too few hits");

  // An empty history gives a zero mean, a filled one a nonzero mean
  a_mean_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> ((results.hit_count == '0) == (results.mean_range == '0)))
    else $error("mean does not match hit count");

  // A zero sample word clears the count at once
  a_zero_clears: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready && (samples.range_sample == '0) |=> hits == '0)
    else $error("zero sample did not clear the hit count");

endmodule

[sv/rtpf_alu.sv]
// ----------------------------------------------------------------------------
// rtpf_alu: shared adder/subtractor
// One add or subtract per cycle; carry out doubles as the
// no-borrow flag for compares and division steps.
// ----------------------------------------------------------------------------
module rtpf_alu (
  input  rtpf_pkg::alu_op_t              op,
  input  logic [rtpf_pkg::ALU_W-1:0]     a,
  input  logic [rtpf_pkg::ALU_W-1:0]     b,
  output rtpf_pkg::alu_res_t             result
);

  logic [rtpf_pkg::ALU_W-1:0] b_x;
  logic                       cin;
  logic [rtpf_pkg::ALU_W:0]   total;

  // Invert and carry in for subtract
  always_comb begin
    cin = (op == rtpf_pkg::ALU_SUB);
    b_x = cin ? ~b : b;
  end

  assign total = {1'b0, a} + {1'b0, b_x} + (rtpf_pkg::ALU_W + 1)'(cin);

  assign result.carry = total[rtpf_pkg::ALU_W];
  assign result.res   = total[rtpf_pkg::ALU_W-1:0];

endmodule

[sv/rtpf_hist.sv]
// ----------------------------------------------------------------------------
// rtpf_hist: sample history store
// Small register file with one write and one read port; a valid bit per
// slot makes a cleared slot read as zero.
// ----------------------------------------------------------------------------
module rtpf_hist #(
  parameter int DEPTH = rtpf_pkg::MIN_HITS_DEF + 1,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clr,
  input  logic                         we,
  input  logic [IDX_W-1:0]             waddr,
  input  logic [rtpf_pkg::RANGE_W-1:0] wdata,
  input  logic [IDX_W-1:0]             raddr,
  output logic [rtpf_pkg::RANGE_W-1:0] rdata
);

  logic [rtpf_pkg::RANGE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]             valid;

  // Drop all slots on reset or on a clear, mark a slot on write
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // Store the written sample
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read, empty slots give zero
  assign rdata = valid[raddr] ? mem[raddr] : '0;

endmodule
